// File: hw/rtl/dense_prim_mst_weight_macros.svh
// Assertion macros shared by the minimum spanning tree weight block.
`ifndef DENSE_PRIM_MST_WEIGHT_MACROS_SVH
`define DENSE_PRIM_MST_WEIGHT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a condition at every clock edge outside reset.
`define DPMW_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("dpmw assertion failed");
// Checks that a condition holds in the cycle after a trigger.
`define DPMW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dpmw assertion failed");
`else
`define DPMW_ASSERT(lbl, expr)
`define DPMW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/dpmw_pkg.sv
// Types and constants shared by the minimum spanning tree weight block.
package dpmw_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int WEIGHT_BITS  = 32;
  localparam int VIDX_BITS    = $clog2(MAX_VERTICES);
  localparam int VCNT_BITS    = VIDX_BITS + 1;
  localparam int ADJ_AW       = 2 * VIDX_BITS;
  localparam int ADJ_DEPTH    = MAX_VERTICES * MAX_VERTICES;
  localparam int LINK_BITS    = WEIGHT_BITS + 1;
  localparam int TOTAL_BITS   = 38;
  localparam int FIELD_V_BITS = 7;
  localparam int FIELD_W_BITS = 32;

  // Link value meaning that no edge reaches the vertex yet.
  localparam logic [LINK_BITS-1:0] NO_LINK = {1'b1, {WEIGHT_BITS{1'b0}}};

  typedef struct packed {
    logic [FIELD_V_BITS-1:0] end_a;
    logic [FIELD_V_BITS-1:0] end_b;
    logic [FIELD_W_BITS-1:0] edge_weight;
    logic                    last_edge;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_BITS-1:0] tree_weight;
    logic                  disconnected;
  } out_item_t;

  typedef struct packed {
    logic                 chosen;
    logic [LINK_BITS-1:0] link;
  } link_entry_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage

// File: hw/rtl/dpmw_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module dpmw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/dpmw_core.sv
// Edge store, Prim sequencer and shared comparator of the spanning tree block.
`include "dense_prim_mst_weight_macros.svh"

module dpmw_core
  import dpmw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_item_t                in_item,
  input  logic [FIELD_V_BITS-1:0] vertex_count,
  input  logic                    slot_free,
  output result_t                 result
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOAD2, S_INIT, S_SCAN, S_MARK, S_RELAX, S_EMIT
  } state_t;

  state_t                  state;
  logic [VIDX_BITS-1:0]    a_idx, b_idx, pick, pend_idx;
  logic [WEIGHT_BITS-1:0]  wgt;
  logic                    last, ends_ok, pend, have, lost;
  logic [VCNT_BITS-1:0]    n, cnt, round;
  logic [LINK_BITS-1:0]    best;
  logic [TOTAL_BITS-1:0]   total;
  logic [ADJ_AW-1:0]       clr_cnt;

  logic                    adj_we;
  logic [ADJ_AW-1:0]       adj_waddr, adj_raddr;
  logic [WEIGHT_BITS-1:0]  adj_wdata, adj_rd;
  logic                    lk_we;
  logic [VIDX_BITS-1:0]    lk_waddr, lk_raddr;
  link_entry_t             lk_wdata, lk_rd;

  logic                    a_ok, b_ok, issue, last_round;
  logic [VCNT_BITS-1:0]    n_clamp;
  logic [LINK_BITS-1:0]    cmp_a, cmp_b;
  logic                    cmp_lt, scan_hit, relax_hit;

  // Endpoints are numbered from 1; anything outside 1..MAX_VERTICES is dropped.
  assign a_ok = (in_item.end_a != '0) &&
                (in_item.end_a <= FIELD_V_BITS'(MAX_VERTICES));
  assign b_ok = (in_item.end_b != '0) &&
                (in_item.end_b <= FIELD_V_BITS'(MAX_VERTICES));
  assign n_clamp = (vertex_count > FIELD_V_BITS'(MAX_VERTICES)) ?
                   VCNT_BITS'(MAX_VERTICES) : VCNT_BITS'(vertex_count);

  assign in_ready   = (state == S_IDLE);
  assign issue      = (cnt < n);
  assign last_round = (round == n - 1'b1);

  // The one comparator, shared by the minimum search and the relaxation.
  always_comb begin
    cmp_a = lk_rd.link;
    cmp_b = best;
    if (state == S_RELAX) begin
      cmp_a = {1'b0, adj_rd};
      cmp_b = lk_rd.link;
    end
  end
  assign cmp_lt    = (cmp_a < cmp_b);
  assign scan_hit  = pend && !lk_rd.chosen && (!have || cmp_lt);
  assign relax_hit = pend && (adj_rd != '0) && !lk_rd.chosen && cmp_lt;

  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = {pick, cnt[VIDX_BITS-1:0]};
    adj_wdata = '0;
    case (state)
      S_IDLE: begin
        adj_we    = in_valid && a_ok && b_ok;
        adj_waddr = {VIDX_BITS'(in_item.end_a - 1'b1), VIDX_BITS'(in_item.end_b - 1'b1)};
        adj_wdata = in_item.edge_weight[WEIGHT_BITS-1:0];
      end
      S_LOAD2: begin
        adj_we    = ends_ok;
        adj_waddr = {b_idx, a_idx};
        adj_wdata = wgt;
      end
      S_CLEAR: begin
        adj_we    = 1'b1;
        adj_waddr = clr_cnt;
      end
      default: adj_we = 1'b0;
    endcase
  end
  assign adj_raddr = {pick, cnt[VIDX_BITS-1:0]};

  always_comb begin
    lk_we    = 1'b0;
    lk_waddr = cnt[VIDX_BITS-1:0];
    lk_wdata = '{chosen: 1'b0, link: NO_LINK};
    case (state)
      S_INIT: begin
        lk_we = 1'b1;
        if (cnt == '0) begin
          lk_wdata.link = '0;
        end
      end
      S_MARK: begin
        lk_we    = 1'b1;
        lk_waddr = pick;
        lk_wdata = '{chosen: 1'b1, link: best};
      end
      S_RELAX: begin
        lk_we    = relax_hit;
        lk_waddr = pend_idx;
        lk_wdata = '{chosen: 1'b0, link: {1'b0, adj_rd}};
      end
      default: lk_we = 1'b0;
    endcase
  end
  assign lk_raddr = cnt[VIDX_BITS-1:0];

  dpmw_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(ADJ_DEPTH)) u_adj (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rd)
  );

  dpmw_ram #(.WIDTH($bits(link_entry_t)), .DEPTH(MAX_VERTICES)) u_link (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (lk_raddr),
    .rdata (lk_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      pend         <= 1'b0;
      have         <= 1'b0;
      lost         <= 1'b0;
      total        <= '0;
      result.valid <= 1'b0;
    end else begin
      result.valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            a_idx   <= VIDX_BITS'(in_item.end_a - 1'b1);
            b_idx   <= VIDX_BITS'(in_item.end_b - 1'b1);
            wgt     <= in_item.edge_weight[WEIGHT_BITS-1:0];
            last    <= in_item.last_edge;
            ends_ok <= a_ok && b_ok;
            state   <= S_LOAD2;
          end
        end
        S_LOAD2: begin
          n     <= n_clamp;
          cnt   <= '0;
          round <= '0;
          total <= '0;
          lost  <= 1'b0;
          if (!last) begin
            state <= S_IDLE;
          end else if (n_clamp == '0) begin
            state <= S_EMIT;
          end else begin
            state <= S_INIT;
          end
        end
        S_INIT: begin
          cnt <= cnt + 1'b1;
          if (cnt == n - 1'b1) begin
            cnt   <= '0;
            have  <= 1'b0;
            pend  <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend     <= issue;
          pend_idx <= cnt[VIDX_BITS-1:0];
          if (issue) begin
            cnt <= cnt + 1'b1;
          end
          if (scan_hit) begin
            have <= 1'b1;
            best <= lk_rd.link;
            pick <= pend_idx;
          end
          if (!issue && !pend) begin
            state <= S_MARK;
          end
        end
        S_MARK: begin
          cnt  <= '0;
          pend <= 1'b0;
          have <= 1'b0;
          if (best == NO_LINK) begin
            lost <= 1'b1;
            if (last_round) begin
              state <= S_EMIT;
            end else begin
              round <= round + 1'b1;
              state <= S_SCAN;
            end
          end else begin
            total <= total + TOTAL_BITS'(best);
            state <= S_RELAX;
          end
        end
        S_RELAX: begin
          pend     <= issue;
          pend_idx <= cnt[VIDX_BITS-1:0];
          if (issue) begin
            cnt <= cnt + 1'b1;
          end
          if (!issue && !pend) begin
            cnt  <= '0;
            have <= 1'b0;
            if (last_round) begin
              state <= S_EMIT;
            end else begin
              round <= round + 1'b1;
              state <= S_SCAN;
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            result.valid             <= 1'b1;
            result.item.tree_weight  <= total;
            result.item.disconnected <= lost;
            clr_cnt                  <= '0;
            state                    <= S_CLEAR;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // A finished search always holds an unchosen vertex inside the graph.
  `DPMW_ASSERT(a_mark_has_pick, (state != S_MARK) || (have && (VCNT_BITS'(pick) < n)))
  // Relaxation only ever lowers a link.
  `DPMW_ASSERT(a_relax_lowers, !(lk_we && (state == S_RELAX)) || (lk_wdata.link < lk_rd.link))
  // A result leaves only from the emit state and is followed by the matrix wipe.
  `DPMW_ASSERT_NEXT(a_emit_then_clear, result.valid, state == S_CLEAR)

endmodule

// File: hw/rtl/dense_prim_mst_weight.sv
// Top level of the minimum spanning tree weight block: ports, register, result slot.
//
// Usage. Edges arrive one per transfer on the in channel (in_valid, in_ready,
// in_item). Each edge is written into a 64 x 64 weight matrix in both
// directions; a later edge between the same pair overwrites the earlier one and
// a weight of zero means no edge. Each edge is written in S_IDLE and then in S_LOAD2,
// as the matrix RAM has a single write port; in_ready is low in S_LOAD2.
// The edge marked last_edge is stored, then Prim's algorithm runs from vertex 1
// over n = min(vertex_count, 64) vertices using one shared comparator that walks
// the matrix row and the link table one vertex per cycle. The link table is seeded
// first; then each of the n rounds runs a search, a mark and a relaxation, a round
// that meets an unreachable vertex skipping its relaxation. One result transfer per
// run carries the tree weight and an unreachable flag. After every run, and after
// reset, the matrix is wiped one entry per cycle and in_ready stays low. The cfg
// channel writes vertex_count and is always ready; it may only be written while the
// block is idle.
// The result waits in an output register; a stalled receiver holds it there and
// the block goes on with its wipe and can load new edges, blocking only when a
// further result is ready before the previous transfer has completed.
module dense_prim_mst_weight
  import dpmw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_item_t                in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_item_t               out_item,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [FIELD_V_BITS-1:0] cfg_data
);

  logic [FIELD_V_BITS-1:0] vertex_count;
  logic                    slot_free;
  result_t                 result;

  // The configuration register is a plain register that takes every transfer.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= FIELD_V_BITS'(1);
    end else if (cfg_valid) begin
      vertex_count <= cfg_data;
    end
  end

  // The core hands over a result in the cycle after it sees the slot free; the
  // slot is free when empty or when its content is being transferred now.
  assign slot_free = !out_valid || out_ready;

  dpmw_core u_core (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_item),
    .vertex_count (vertex_count),
    .slot_free    (slot_free),
    .result       (result)
  );

  // Output register: holds the result steady until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      out_item <= result.item;
    end
  end

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the dense Prim minimum spanning tree weight block.
module tb_top
  import dpmw_pkg::*;
();

  // Edge transfers in the random part, on top of the directed probes.
  localparam int RANDOM_ITEMS        = 1950;
  // This pause covers the matrix wipe after a run with margin.
  localparam int CLEAR_SETTLE_CYCLES = 4200;
  localparam int END_DRAIN_CYCLES    = 200;
  localparam int WATCHDOG_TIME       = 10_000_000;
  localparam int REPORT_LIMIT        = 10;
  localparam int PROBE_ROWS          = 24;
  localparam int PLAN_LEN            = 13;

  typedef enum logic {ROW_EDGE, ROW_CFG} row_kind_t;

  // One directed probe: either a vertex count write or an edge transfer. Where the
  // tree weight is obvious it is typed in; otherwise the predictor supplies it.
  typedef struct packed {
    row_kind_t               kind;
    logic [FIELD_V_BITS-1:0] count;
    logic [FIELD_V_BITS-1:0] a;
    logic [FIELD_V_BITS-1:0] b;
    logic [FIELD_W_BITS-1:0] w;
    logic                    last;
    logic                    typed;
    logic [TOTAL_BITS-1:0]   tw;
    logic                    disc;
  } probe_row_t;

  probe_row_t probes [PROBE_ROWS] = '{
    // Reset vertex count of one, with an edge beyond the count: nothing to span.
    '{ROW_EDGE, 7'd0,   7'd1,   7'd2,   32'd5,         1'b1, 1'b1, 38'd0,         1'b0},
    // An empty graph gives a zero total and no unreachable vertex.
    '{ROW_CFG,  7'd0,   7'd0,   7'd0,   32'd0,         1'b0, 1'b0, 38'd0,         1'b0},
    '{ROW_EDGE, 7'd0,   7'd2,   7'd3,   32'd9,         1'b1, 1'b1, 38'd0,         1'b0},
    // Two vertices joined by the heaviest weight, then by a zero weight (no edge).
    '{ROW_CFG,  7'd2,   7'd0,   7'd0,   32'd0,         1'b0, 1'b0, 38'd0,         1'b0},
    '{ROW_EDGE, 7'd0,   7'd1,   7'd2,   32'hFFFF_FFFF, 1'b1, 1'b1, 38'hFFFF_FFFF, 1'b0},
    '{ROW_EDGE, 7'd0,   7'd2,   7'd1,   32'd0,         1'b1, 1'b1, 38'd0,         1'b1},
    // An oversized count acts as the full 64; out-of-range endpoints are dropped.
    '{ROW_CFG,  7'd127, 7'd0,   7'd0,   32'd0,         1'b0, 1'b0, 38'd0,         1'b0},
    '{ROW_EDGE, 7'd0,   7'd0,   7'd5,   32'd7,         1'b0, 1'b0, 38'd0,         1'b0},
    '{ROW_EDGE, 7'd0,   7'd65,  7'd1,   32'd7,         1'b0, 1'b0, 38'd0,         1'b0},
    '{ROW_EDGE, 7'd0,   7'd127, 7'd127, 32'd7,         1'b0, 1'b0, 38'd0,         1'b0},
    '{ROW_EDGE, 7'd0,   7'd1,   7'd64,  32'hFFFF_FFFF, 1'b1, 1'b1, 38'hFFFF_FFFF, 1'b1},
    // Overwrite of a pair, a tie between vertices, an edge beyond the count.
    '{ROW_CFG,  7'd3,   7'd0,   7'd0,   32'd0,         1'b0, 1'b0, 38'd0,         1'b0},
    '{ROW_EDGE, 7'd0,   7'd1,   7'd2,   32'd10,        1'b0, 1'b0, 38'd0,         1'b0},
    '{ROW_EDGE, 7'd0,   7'd2,   7'd1,   32'd4,         1'b0, 1'b0, 38'd0,         1'b0},
    '{ROW_EDGE, 7'd0,   7'd2,   7'd3,   32'd4,         1'b0, 1'b0, 38'd0,         1'b0},
    '{ROW_EDGE, 7'd0,   7'd1,   7'd3,   32'd4,         1'b0, 1'b0, 38'd0,         1'b0},
    '{ROW_EDGE, 7'd0,   7'd1,   7'd4,   32'd1,         1'b0, 1'b0, 38'd0,         1'b0},
    '{ROW_EDGE, 7'd0,   7'd3,   7'd3,   32'd1,         1'b1, 1'b0, 38'd0,         1'b0},
    // Edges loaded under one count and used under another.
    '{ROW_EDGE, 7'd0,   7'd1,   7'd2,   32'd3,         1'b0, 1'b0, 38'd0,         1'b0},
    '{ROW_CFG,  7'd2,   7'd0,   7'd0,   32'd0,         1'b0, 1'b0, 38'd0,         1'b0},
    '{ROW_EDGE, 7'd0,   7'd2,   7'd2,   32'd0,         1'b1, 1'b0, 38'd0,         1'b0},
    // Highest vertex numbers in a mostly unreachable 64-vertex graph.
    '{ROW_CFG,  7'd64,  7'd0,   7'd0,   32'd0,         1'b0, 1'b0, 38'd0,         1'b0},
    '{ROW_EDGE, 7'd0,   7'd64,  7'd63,  32'd1,         1'b0, 1'b0, 38'd0,         1'b0},
    '{ROW_EDGE, 7'd0,   7'd63,  7'd1,   32'd2,         1'b1, 1'b0, 38'd0,         1'b0}
  };

  // Vertex count settings visited by the random part, in turn; the extremes recur.
  int count_plan [PLAN_LEN] = '{5, 2, 12, 64, 8, 0, 3, 127, 20, 1, 7, 40, 4};

  logic                    clk;
  logic                    rst       = 1'b1;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  in_item_t                in_item   = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  out_item_t               out_item;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [FIELD_V_BITS-1:0] cfg_data  = '0;

  // Predictor state: its own copy of the weight matrix and of the vertex count.
  logic [WEIGHT_BITS-1:0]  weight_mat [MAX_VERTICES][MAX_VERTICES];
  logic [FIELD_V_BITS-1:0] vertex_count_model;
  out_item_t               awaited_totals [$];
  out_item_t               oldest_total;

  int edges_sent       = 0;
  int results_seen     = 0;
  int unreachable_seen = 0;
  int mismatch_count   = 0;
  int counts_written   = 0;
  int calm_after       = 32'h7FFF_FFFF;
  bit calm             = 1'b0;
  int sender_idle_pct  = 30;

  int ready_stall_left = 0;
  int ready_stall_pct  = 0;
  int ready_mode_left  = 0;

  dense_prim_mst_weight u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(WATCHDOG_TIME);
    $display("TEST FAILED");
    $finish;
  end

  // Dense Prim from vertex 1 over the first n vertices. Each round takes the
  // unchosen vertex with the smallest link (lowest number on a tie), adds that
  // link to the total and relaxes the row. A vertex still at the no-link value
  // when chosen was unreachable and marks the graph as disconnected.
  function automatic out_item_t prim_tree_total();
    int                    n;
    int                    pick;
    bit                    have;
    bit                    lost;
    bit                    taken [MAX_VERTICES];
    logic [LINK_BITS-1:0]  key [MAX_VERTICES];
    logic [LINK_BITS-1:0]  w;
    logic [TOTAL_BITS-1:0] sum;
    out_item_t             tree;
    n    = (vertex_count_model > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count_model);
    sum  = '0;
    lost = 1'b0;
    for (int v = 0; v < n; v++) begin
      key[v]   = NO_LINK;
      taken[v] = 1'b0;
    end
    if (n > 0) key[0] = '0;
    for (int i = 0; i < n; i++) begin
      pick = 0;
      have = 1'b0;
      for (int v = 0; v < n; v++) begin
        if (!taken[v] && (!have || key[v] < key[pick])) begin
          pick = v;
          have = 1'b1;
        end
      end
      taken[pick] = 1'b1;
      if (key[pick] == NO_LINK) begin
        lost = 1'b1;
        continue;
      end
      sum = sum + TOTAL_BITS'(key[pick]);
      for (int v = 0; v < n; v++) begin
        w = LINK_BITS'(weight_mat[pick][v]);
        if (w != '0 && !taken[v] && w < key[v]) key[v] = w;
      end
    end
    tree.tree_weight  = sum;
    tree.disconnected = lost;
    return tree;
  endfunction

  function automatic void clear_matrix();
    for (int r = 0; r < MAX_VERTICES; r++)
      for (int c = 0; c < MAX_VERTICES; c++) weight_mat[r][c] = '0;
  endfunction

  // Applies one accepted edge to the model. A last edge also queues the tree
  // weight, either the one typed into a probe or the predicted one.
  function automatic void accept_edge(input in_item_t it, input bit typed,
                                      input out_item_t typed_result);
    out_item_t tree;
    if (it.end_a >= 1 && it.end_a <= MAX_VERTICES && it.end_b >= 1 &&
        it.end_b <= MAX_VERTICES) begin
      weight_mat[it.end_a - 1][it.end_b - 1] = it.edge_weight[WEIGHT_BITS-1:0];
      weight_mat[it.end_b - 1][it.end_a - 1] = it.edge_weight[WEIGHT_BITS-1:0];
    end
    if (it.last_edge) begin
      tree = prim_tree_total();
      awaited_totals.push_back(typed ? typed_result : tree);
      clear_matrix();
    end
  endfunction

  function automatic in_item_t mk_edge(input int a, input int b, input logic [31:0] w);
    in_item_t it;
    it.end_a       = FIELD_V_BITS'(a);
    it.end_b       = FIELD_V_BITS'(b);
    it.edge_weight = w;
    it.last_edge   = 1'b0;
    return it;
  endfunction

  // Small weights are frequent so that ties and overwrites matter; zero removes an
  // edge and weights near the top of the range stress the total.
  function automatic logic [31:0] link_weight();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1, 2, 3: return 32'($urandom_range(1, 6));
      4:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 2));
      default: return $urandom();
    endcase
  endfunction

  // Offers one edge and holds it until the transfer completes. Valid is left high
  // afterwards; the next call or the caller decides whether it drops.
  task automatic send_edge(input in_item_t it, input bit typed, input out_item_t typed_result);
    if (!calm && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    edges_sent++;
    accept_edge(it, typed, typed_result);
    if (edges_sent >= calm_after) calm = 1'b1;
  endtask

  // Holds the sender back until every queued tree weight has been delivered.
  task automatic park_sender();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_totals.size() != 0);
  endtask

  // The count may only change while the block is idle, so the sender first waits
  // for the last result and then lets the matrix wipe run to its end.
  task automatic write_vertex_count(input logic [FIELD_V_BITS-1:0] value);
    park_sender();
    repeat (CLEAR_SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    vertex_count_model = value;
    counts_written++;
  endtask

  // One graph ending in a last edge. Most graphs are built on a random spanning
  // tree so that Prim reaches every vertex; some lose tree edges on purpose.
  // Extra edges, overwrites and out-of-range noise are mixed in, then shuffled.
  task automatic send_graph(input int n);
    in_item_t batch [$];
    int       order [$];
    in_item_t twin;
    int       j;
    int       tmp;
    int       span;
    bit       broken;
    span = (n > 0) ? n : 8;
    for (int v = 1; v <= n; v++) order.push_back(v);
    for (int i = n - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    broken = ($urandom_range(0, 4) == 0);
    for (int i = 1; i < n; i++)
      if (!broken || $urandom_range(0, 3) != 0)
        batch.push_back(mk_edge(order[i], order[$urandom_range(0, i - 1)], link_weight()));
    repeat ($urandom_range(0, n + 2))
      batch.push_back(mk_edge($urandom_range(1, span), $urandom_range(1, span), link_weight()));
    repeat ($urandom_range(0, 2))
      batch.push_back(mk_edge($urandom_range(0, 127), $urandom_range(0, 127), $urandom()));
    if (batch.size() != 0 && $urandom_range(0, 2) == 0) begin
      // Same pair again, written the other way round with a fresh weight.
      j                = $urandom_range(0, batch.size() - 1);
      twin             = batch[j];
      twin.end_a       = batch[j].end_b;
      twin.end_b       = batch[j].end_a;
      twin.edge_weight = link_weight();
      batch.push_back(twin);
    end
    if (batch.size() == 0)
      batch.push_back(mk_edge($urandom_range(0, 127), $urandom_range(0, 127), $urandom()));
    for (int i = batch.size() - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      twin     = batch[i];
      batch[i] = batch[j];
      batch[j] = twin;
    end
    batch[batch.size() - 1].last_edge = 1'b1;
    sender_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
    if (!calm && $urandom_range(0, 9) == 0) park_sender();
    foreach (batch[i]) send_edge(batch[i], 1'b0, '0);
  endtask

  // Receiver back-pressure: random stall bursts, with quiet stretches in between,
  // and none at all once the run has gone calm.
  always @(posedge clk) begin
    if (ready_mode_left == 0) begin
      ready_mode_left = $urandom_range(50, 400);
      ready_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 40;
    end else begin
      ready_mode_left--;
    end
    if (calm) begin
      out_ready <= 1'b1;
    end else if (ready_stall_left > 0) begin
      ready_stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < ready_stall_pct) begin
      ready_stall_left = $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every result transfer is checked against the oldest queued tree weight.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_totals.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT)
          $display("Unexpected result: tree_weight %0d disconnected %0d",
                   out_item.tree_weight, out_item.disconnected);
        mismatch_count++;
      end else begin
        oldest_total = awaited_totals.pop_front();
        results_seen++;
        if (oldest_total.disconnected) unreachable_seen++;
        if (out_item.tree_weight !== oldest_total.tree_weight ||
            out_item.disconnected !== oldest_total.disconnected) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("Result %0d: expected tree_weight %0d disconnected %0d, got %0d %0d",
                     results_seen, oldest_total.tree_weight, oldest_total.disconnected,
                     out_item.tree_weight, out_item.disconnected);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    in_item_t  probe_item;
    out_item_t probe_result;
    int        item_goal;
    int        phase;
    int        runs;
    int        plan_count;
    clear_matrix();
    vertex_count_model = 7'd1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed probes, walked in order.
    for (int r = 0; r < PROBE_ROWS; r++) begin
      if (probes[r].kind == ROW_CFG) begin
        write_vertex_count(probes[r].count);
      end else begin
        probe_item.end_a          = probes[r].a;
        probe_item.end_b          = probes[r].b;
        probe_item.edge_weight    = probes[r].w;
        probe_item.last_edge      = probes[r].last;
        probe_result.tree_weight  = probes[r].tw;
        probe_result.disconnected = probes[r].disc;
        send_edge(probe_item, probes[r].typed, probe_result);
      end
    end

    // Random graphs, six per vertex count below 40; the larger counts get a single run
    // each since a run then takes much longer.
    item_goal  = edges_sent + RANDOM_ITEMS;
    calm_after = edges_sent + RANDOM_ITEMS * 9 / 10;
    phase      = 0;
    while (edges_sent < item_goal) begin
      plan_count = count_plan[phase % PLAN_LEN];
      write_vertex_count(FIELD_V_BITS'(plan_count));
      runs = (plan_count >= 40) ? 1 : 6;
      for (int k = 0; k < runs && edges_sent < item_goal; k++)
        send_graph((plan_count > MAX_VERTICES) ? MAX_VERTICES : plan_count);
      phase++;
    end

    park_sender();
    repeat (END_DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d edges under %0d vertex counts;", edges_sent, counts_written);
    $display("checked %0d tree weights (%0d disconnected).", results_seen, unreachable_seen);
    if (mismatch_count == 0 && awaited_totals.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/dpmw_pkg.sv
hw/rtl/dpmw_ram.sv
hw/rtl/dpmw_core.sv
hw/rtl/dense_prim_mst_weight.sv
sim/tb_top.sv
